FILE: hw/rtl/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types, widths and the quarter-wave sine table for the tone generator.
// ----------------------------------------------------------------------------
package stg_pkg;

    localparam int QTE       = 256;
    localparam int QW        = $clog2(QTE);
    localparam int PH_W      = QW + 2;
    localparam int FRAC_W    = 16;
    localparam int POS_W     = PH_W + FRAC_W;
    localparam int RATE_W    = 18;
    localparam int IDX_W     = 31;
    localparam int AMP_W     = 16;
    localparam int CH_W      = 2;
    localparam int SMP_W     = 16;
    localparam int PROD_W    = IDX_W + RATE_W;
    localparam int CNT_W     = $clog2(PROD_W + 1);
    localparam int MUL_W     = 32;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int DIFF_W    = SMP_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE = 2'd0,
        CFG_FREQ = 2'd1,
        CFG_AMP  = 2'd2,
        CFG_CHAN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             load_index;
        logic [IDX_W-1:0] start_index;
        logic             block_end;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_value;
        logic                    channel;
        logic                    last;
        logic                    block_done;
        logic [IDX_W-1:0]        next_index;
    } t_out;

    typedef logic [SMP_W-1:0] t_rom [0:QTE];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        for (int k = 0; k <= QTE; k++) begin
            x  = (64'(k) * 64'd1686629713 + 64'(QTE / 2)) / 64'(QTE);
            x2 = (x * x + (64'd1 << 29)) >> 30;
            t  = 64'd1 << 30;
            t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd156);
            t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
            t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
            t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
            t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
            t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
            s  = (x * t) >> 30;
            v  = (s + (64'd1 << 14)) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[k] = v[SMP_W-1:0];
        end
        return rom;
    endfunction

    localparam t_rom QROM = build_rom();

    // full-wave lookup by quadrant folding of the quarter table
    function automatic logic signed [SMP_W-1:0] full_wave(input logic [PH_W-1:0] idx);
        logic [QW:0]      k;
        logic [SMP_W-1:0] m;
        k = {1'b0, idx[QW-1:0]};
        if (idx[QW]) begin
            k = (QW + 1)'(QTE) - k;
        end
        m = QROM[k];
        return idx[QW+1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: hw/rtl/stg_div_step.sv
// ----------------------------------------------------------------------------
// stg_div_step
// One restoring shift-subtract step against the sample rate, shared by the
// frequency reduction, the residue rebuild and the phase position division.
// ----------------------------------------------------------------------------
module stg_div_step (
    input  logic [stg_pkg::RATE_W-1:0] i_rem,
    input  logic                       i_bit,
    input  logic [stg_pkg::RATE_W-1:0] i_div,
    output logic [stg_pkg::RATE_W-1:0] o_rem,
    output logic                       o_q
);
    import stg_pkg::*;

    logic [RATE_W:0] w_t;
    logic [RATE_W:0] w_d;
    logic [RATE_W:0] w_diff;

    assign w_t    = {i_rem, i_bit};
    assign w_d    = {1'b0, i_div};
    assign w_diff = w_t - w_d;
    assign o_q    = (w_t >= w_d);
    assign o_rem  = o_q ? w_diff[RATE_W-1:0] : w_t[RATE_W-1:0];

endmodule

FILE: hw/rtl/stg_mul.sv
// ----------------------------------------------------------------------------
// stg_mul
// Shared registered signed multiplier for index, interpolation and volume.
// ----------------------------------------------------------------------------
module stg_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [stg_pkg::MUL_W-1:0]  i_a,
    input  logic signed [stg_pkg::MUL_W-1:0]  i_b,
    output logic signed [2*stg_pkg::MUL_W-1:0] o_p
);
    import stg_pkg::*;

    logic signed [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

FILE: hw/rtl/sine_tone_generator_top.sv
// ----------------------------------------------------------------------------
// sine_tone_generator_top
// Sine tone sample generator: exact phase residue, quarter-wave table with
// linear interpolation, volume scaling and 16-bit saturation.
// ----------------------------------------------------------------------------
// the phase position takes 26 steps of the shared divide-step unit
// a load_index beat adds the index multiply and a 49-step residue mod
// the first beat after a rate or freq write adds both and an 18-step freq mod
// input beats are taken only when idle, after the last result is registered;
//   stereo gives two output beats
// reset: synchronous active low; configuration registers return to defaults,
//   index and residue to zero
module sine_tone_generator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  stg_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output stg_pkg::t_out              o_out_data,
    input  logic                       i_cfg_we,
    input  stg_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [stg_pkg::CFG_W-1:0]  i_cfg_data
);
    import stg_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_FMOD = 12'b0000_0000_0010,
        S_MUL  = 12'b0000_0000_0100,
        S_RLD  = 12'b0000_0000_1000,
        S_RMOD = 12'b0000_0001_0000,
        S_POS  = 12'b0000_0010_0000,
        S_ROM0 = 12'b0000_0100_0000,
        S_ROM1 = 12'b0000_1000_0000,
        S_MULF = 12'b0001_0000_0000,
        S_ADDR = 12'b0010_0000_0000,
        S_MULA = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [RATE_W-1:0] r_rate;
    logic [RATE_W-1:0] r_freq;
    logic [AMP_W-1:0]  r_amp;
    logic [CH_W-1:0]   r_chan;
    logic              r_dirty;

    logic [IDX_W-1:0]  r_counter;
    logic [RATE_W-1:0] r_residue;
    logic [RATE_W-1:0] r_ef;

    logic [PROD_W-1:0] r_dvd;
    logic [RATE_W-1:0] r_rem;
    logic [POS_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_bend;

    logic signed [SMP_W-1:0]  r_w0;
    logic signed [DIFF_W-1:0] r_d;
    logic signed [MUL_W-1:0]  r_r;

    logic                     r_ovalid;
    logic                     r_och;
    logic                     r_ostereo;
    logic                     r_obend;
    logic signed [SMP_W-1:0]  r_osmp;
    logic [IDX_W-1:0]         r_onidx;

    logic [RATE_W-1:0]         w_rate;
    logic [RATE_W-1:0]         w_rem_n;
    logic                      w_q;
    logic                      w_step_end;
    logic [PH_W-1:0]           w_idx;
    logic [FRAC_W-1:0]         w_frac;
    logic [RATE_W:0]           w_sum;
    logic [RATE_W:0]           w_sub;
    logic [RATE_W-1:0]         w_nres;
    logic                      w_men;
    logic signed [MUL_W-1:0]   w_ma;
    logic signed [MUL_W-1:0]   w_mb;
    logic signed [2*MUL_W-1:0] w_prod;
    logic signed [2*MUL_W-1:0] w_adj;
    logic signed [2*MUL_W-1:0] w_v;
    logic signed [SMP_W-1:0]   w_sat;
    logic                      w_olast;

    assign w_rate     = (r_rate == '0) ? RATE_W'(1) : r_rate;
    assign w_step_end = (r_cnt == CNT_W'(1));
    assign w_idx      = r_quo[POS_W-1:FRAC_W];
    assign w_frac     = r_quo[FRAC_W-1:0];

    stg_div_step u_div (
        .i_rem (r_rem),
        .i_bit (r_dvd[PROD_W-1]),
        .i_div (w_rate),
        .o_rem (w_rem_n),
        .o_q   (w_q)
    );

    // residue advance
    assign w_sum  = {1'b0, r_residue} + {1'b0, r_ef};
    assign w_sub  = w_sum - {1'b0, w_rate};
    assign w_nres = (w_sum >= {1'b0, w_rate}) ? w_sub[RATE_W-1:0] : w_sum[RATE_W-1:0];

    // shared multiplier operand select
    always_comb begin
        w_men = 1'b0;
        w_ma  = '0;
        w_mb  = '0;
        unique case (r_state)
            S_MUL: begin
                w_men = 1'b1;
                w_ma  = $signed({{(MUL_W-IDX_W){1'b0}}, r_counter});
                w_mb  = $signed({{(MUL_W-RATE_W){1'b0}}, r_ef});
            end
            S_MULF: begin
                w_men = 1'b1;
                w_ma  = {{(MUL_W-DIFF_W){r_d[DIFF_W-1]}}, r_d};
                w_mb  = $signed({{(MUL_W-FRAC_W){1'b0}}, w_frac});
            end
            S_MULA: begin
                w_men = 1'b1;
                w_ma  = $signed({{(MUL_W-AMP_W){1'b0}}, r_amp});
                w_mb  = r_r;
            end
            default: begin
                w_men = 1'b0;
            end
        endcase
    end

    stg_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_men),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // truncate toward zero, then saturate
    always_comb begin
        w_adj = w_prod + (w_prod[2*MUL_W-1] ? $signed(64'h7FFF_FFFF) : $signed(64'h0));
        w_v   = w_adj >>> 31;
        if (w_v > $signed(64'sd32767)) begin
            w_sat = 16'sh7FFF;
        end else if (w_v < -$signed(64'sd32768)) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_v[SMP_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_dirty) begin
                        n_state = S_FMOD;
                    end else if (i_in_data.load_index) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_POS;
                    end
                end
            end
            S_FMOD: begin
                if (w_step_end) n_state = S_MUL;
            end
            S_MUL:  n_state = S_RLD;
            S_RLD:  n_state = S_RMOD;
            S_RMOD: begin
                if (w_step_end) n_state = S_POS;
            end
            S_POS: begin
                if (w_step_end) n_state = S_ROM0;
            end
            S_ROM0: n_state = S_ROM1;
            S_ROM1: n_state = S_MULF;
            S_MULF: n_state = S_ADDR;
            S_ADDR: n_state = S_MULA;
            S_MULA: n_state = S_FIN;
            S_FIN: begin
                if (!r_ovalid) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rate    <= RATE_W'(48000);
            r_freq    <= RATE_W'(1000);
            r_amp     <= AMP_W'(8000);
            r_chan    <= CH_W'(1);
            r_dirty   <= 1'b1;
            r_counter <= '0;
            r_residue <= '0;
            r_ovalid  <= 1'b0;
            r_och     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE: begin
                        r_rate  <= i_cfg_data[RATE_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    CFG_FREQ: begin
                        r_freq  <= i_cfg_data[RATE_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    CFG_AMP:  r_amp  <= i_cfg_data[AMP_W-1:0];
                    CFG_CHAN: r_chan <= i_cfg_data[CH_W-1:0];
                    default:  r_amp  <= r_amp;
                endcase
            end else if (r_state == S_FMOD && w_step_end) begin
                r_dirty <= 1'b0;
            end
            if (r_state == S_IDLE && i_in_valid && i_in_data.load_index) begin
                r_counter <= i_in_data.start_index;
            end
            if (r_state == S_RMOD && w_step_end) begin
                r_residue <= w_rem_n;
            end
            if (r_state == S_ROM0) begin
                r_counter <= r_counter + IDX_W'(1);
                r_residue <= w_nres;
            end
            if (r_state == S_FIN && !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_och    <= 1'b0;
            end else if (r_ovalid && i_out_ready) begin
                if (r_ostereo && !r_och) begin
                    r_och <= 1'b1;
                end else begin
                    r_ovalid <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_bend <= i_in_data.block_end;
                r_rem  <= r_dirty ? '0 : r_residue;
                r_dvd  <= r_dirty ? {r_freq, {(PROD_W-RATE_W){1'b0}}} : '0;
                r_cnt  <= r_dirty ? CNT_W'(RATE_W) : CNT_W'(POS_W);
            end
            S_FMOD: begin
                r_rem <= w_rem_n;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (w_step_end) begin
                    r_ef <= w_rem_n;
                end
            end
            S_RLD: begin
                r_dvd <= w_prod[PROD_W-1:0];
                r_rem <= '0;
                r_cnt <= CNT_W'(PROD_W);
            end
            S_RMOD: begin
                r_rem <= w_rem_n;
                r_dvd <= r_dvd << 1;
                r_cnt <= w_step_end ? CNT_W'(POS_W) : r_cnt - CNT_W'(1);
            end
            S_POS: begin
                r_rem <= w_rem_n;
                r_dvd <= r_dvd << 1;
                r_quo <= {r_quo[POS_W-2:0], w_q};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_ROM0: r_w0 <= full_wave(w_idx);
            S_ROM1: r_d  <= DIFF_W'(full_wave(w_idx + PH_W'(1))) - DIFF_W'(r_w0);
            S_ADDR: r_r  <= $signed({r_w0, {FRAC_W{1'b0}}}) + w_prod[MUL_W-1:0];
            S_FIN: begin
                if (!r_ovalid) begin
                    r_osmp    <= w_sat;
                    r_ostereo <= (r_chan != CH_W'(1));
                    r_obend   <= r_bend;
                    r_onidx   <= r_counter;
                end
            end
            default: r_bend <= r_bend;
        endcase
    end

    assign w_olast     = !r_ostereo || r_och;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_out_data.sample_value = r_osmp;
        o_out_data.channel      = r_och;
        o_out_data.last         = w_olast;
        o_out_data.block_done   = w_olast && r_obend;
        o_out_data.next_index   = r_onidx;
    end

endmodule

FILE: test/sine_tone_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_generator_top_tb
// Drives tone sample requests and register settings into the generator,
// predicts every sample beat from its own phase residue, sine table and
// scaling, and checks each output beat field by field under random idling
// and one long output stall.
// ----------------------------------------------------------------------------

class tone_scoreboard;

    localparam int unsigned QUARTER = 256;

    bit [17:0]       rate;
    bit [17:0]       freq;
    bit [15:0]       amp;
    bit [1:0]        chans;
    bit [30:0]       counter;
    int unsigned     residue;
    int unsigned     sine_quarter [0:QUARTER];
    stg_pkg::t_out   expected_samples [$];
    int              errors;
    int              beats_seen;

    function new();
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] t;
        bit [63:0] v;
        int unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
        rate       = 18'd48000;
        freq       = 18'd1000;
        amp        = 16'd8000;
        chans      = 2'd1;
        counter    = '0;
        residue    = 0;
        errors     = 0;
        beats_seen = 0;
        for (int k = 0; k <= QUARTER; k++) begin
            x  = (64'(k) * 64'd1686629713 + 64'(QUARTER / 2)) / 64'(QUARTER);
            x2 = (x * x + (64'd1 << 29)) >> 30;
            t  = 64'd1 << 30;
            foreach (divs[i]) begin
                t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'(divs[i]));
            end
            v = (((x * t) >> 30) + (64'd1 << 14)) >> 15;
            sine_quarter[k] = (v > 64'd32767) ? 32767 : int'(v);
        end
    endfunction

    function int unsigned eff_rate();
        return (rate == 0) ? 1 : int'(rate);
    endfunction

    function int unsigned eff_freq();
        return int'(freq) % eff_rate();
    endfunction

    function void rebuild_residue();
        residue = int'((64'(counter) * 64'(eff_freq())) % 64'(eff_rate()));
    endfunction

    function int wave_point(int unsigned i);
        int unsigned q;
        int unsigned k;
        i = i % (4 * QUARTER);
        q = i / QUARTER;
        k = i % QUARTER;
        if (q[0]) begin
            k = QUARTER - k;
        end
        return (q >= 2) ? -int'(sine_quarter[k]) : int'(sine_quarter[k]);
    endfunction

    function bit [15:0] sample_at_phase();
        bit [63:0]   pos;
        int unsigned idx;
        longint      f;
        longint      r;
        longint      v;
        pos = ((64'(residue) * 64'(4 * QUARTER)) << 16) / 64'(eff_rate());
        idx = int'(pos >> 16);
        f   = longint'(pos & 64'hFFFF);
        r   = longint'(wave_point(idx)) * (65536 - f) + longint'(wave_point(idx + 1)) * f;
        v   = (longint'(amp) * r) / (longint'(1) << 31);
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    function void write_reg(stg_pkg::t_cfg_idx idx, bit [17:0] data);
        case (idx)
            stg_pkg::CFG_RATE: begin
                rate = data;
                rebuild_residue();
            end
            stg_pkg::CFG_FREQ: begin
                freq = data;
                rebuild_residue();
            end
            stg_pkg::CFG_AMP:  amp = data[15:0];
            stg_pkg::CFG_CHAN: chans = data[1:0];
            default: ;
        endcase
    endfunction

    function void note_request(stg_pkg::t_in req);
        stg_pkg::t_out beat;
        bit [15:0]     value;
        int            n;
        if (req.load_index) begin
            counter = req.start_index;
            rebuild_residue();
        end
        value   = sample_at_phase();
        counter = counter + 31'd1;
        residue = residue + eff_freq();
        if (residue >= eff_rate()) begin
            residue = residue - eff_rate();
        end
        n = (chans == 2'd1) ? 1 : 2;
        for (int k = 0; k < n; k++) begin
            beat.sample_value = value;
            beat.channel      = (k == 1);
            beat.last         = (k == n - 1);
            beat.block_done   = (k == n - 1) && req.block_end;
            beat.next_index   = counter;
            expected_samples.push_back(beat);
        end
    endfunction

    function void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endfunction

    function void check_sample(stg_pkg::t_out got);
        stg_pkg::t_out want;
        beats_seen++;
        if (expected_samples.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected beat, expected none, actual sample %0d index %0d",
                     $time, $signed(got.sample_value), got.next_index);
            return;
        end
        want = expected_samples.pop_front();
        check_field("sample_value", longint'($signed(want.sample_value)),
                    longint'($signed(got.sample_value)));
        check_field("channel", want.channel, got.channel);
        check_field("last", want.last, got.last);
        check_field("block_done", want.block_done, got.block_done);
        check_field("next_index", want.next_index, got.next_index);
    endfunction

endclass

module sine_tone_generator_top_tb;

    import stg_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in                 i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out                o_out_data;
    logic                i_cfg_we    = 1'b0;
    t_cfg_idx            i_cfg_idx   = CFG_RATE;
    logic [CFG_W-1:0]    i_cfg_data  = '0;

    tone_scoreboard      sb;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_left     = 0;
    bit                  hold_done     = 1'b0;
    int                  quiet_cycles  = 0;

    sine_tone_generator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver with one long hold-off so the block backs up into its input
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && sb.beats_seen >= 300 && i_in_valid) begin
            hold_done   = 1'b1;
            hold_left   = 600;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (o_out_valid && i_out_ready) begin
                sb.check_sample(o_out_data);
                quiet_cycles = 0;
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_in_data);
                quiet_cycles = 0;
            end
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_idx, i_cfg_data);
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_request(bit load, bit [30:0] start, bit bend);
        t_in req;
        req.load_index  = load;
        req.start_index = start;
        req.block_end   = bend;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    task automatic send_random();
        bit [30:0] start;
        start = ($urandom_range(4) == 0) ? 31'h7FFF_FFFF - 31'($urandom_range(40))
                                         : 31'($urandom);
        send_request($urandom_range(9) == 0, start, $urandom_range(4) == 0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_samples.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_setting(t_cfg_idx idx, bit [17:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic retune();
        bit [17:0] rate;
        bit [17:0] freq;
        case ($urandom_range(9))
            0: rate = 18'd8000;
            1: rate = 18'd16000;
            2: rate = 18'd44100;
            3: rate = 18'd48000;
            4: rate = 18'd96000;
            5: rate = 18'd192000;
            6, 7: rate = 18'($urandom_range(1, 262143));
            8: rate = 18'($urandom_range(1, 16));
            default: rate = $urandom_range(1) ? 18'h3FFFF : 18'd0;
        endcase
        case ($urandom_range(3))
            0, 1: freq = 18'($urandom_range(0, (rate == 0) ? 0 : rate - 1));
            2: freq = 18'($urandom_range(0, 262143));
            default: freq = 18'($urandom_range(0, 3000));
        endcase
        write_setting(CFG_RATE, rate);
        write_setting(CFG_FREQ, freq);
        case ($urandom_range(5))
            0: write_setting(CFG_AMP, 18'd0);
            1: write_setting(CFG_AMP, 18'd65535);
            2: write_setting(CFG_AMP, 18'($urandom));
            default: write_setting(CFG_AMP, 18'($urandom_range(0, 65535)));
        endcase
        write_setting(CFG_CHAN, 18'($urandom));
    endtask

    initial begin
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults, block end, index wrap
        send_request(1'b0, 31'd0, 1'b0);
        send_request(1'b0, 31'h5555_5555, 1'b1);
        send_request(1'b1, 31'h7FFF_FFFF, 1'b0);
        send_request(1'b0, 31'd0, 1'b1);
        drain();

        // quarter turns at full volume saturate both ways, stereo
        write_setting(CFG_RATE, 18'd4);
        write_setting(CFG_FREQ, 18'd1);
        write_setting(CFG_AMP, 18'h3FFFF);
        write_setting(CFG_CHAN, 18'd2);
        send_request(1'b1, 31'd0, 1'b0);
        repeat (3) send_request(1'b0, 31'h2AAA_AAAA, 1'b1);
        drain();

        // zero rate, channel count zero
        write_setting(CFG_RATE, 18'd0);
        write_setting(CFG_FREQ, 18'd5);
        write_setting(CFG_CHAN, 18'd0);
        send_request(1'b1, 31'd12345, 1'b1);
        send_request(1'b0, 31'd0, 1'b0);
        drain();

        // widest rate, frequency equal to rate, channel count three
        write_setting(CFG_RATE, 18'h3FFFF);
        write_setting(CFG_FREQ, 18'h3FFFF);
        write_setting(CFG_AMP, 18'd12345);
        write_setting(CFG_CHAN, 18'd3);
        send_request(1'b1, 31'h7FFF_FFFE, 1'b0);
        send_request(1'b0, 31'd0, 1'b1);
        drain();

        // frequency above rate, mono, full volume
        write_setting(CFG_RATE, 18'd1000);
        write_setting(CFG_FREQ, 18'd262143);
        write_setting(CFG_AMP, 18'd65535);
        write_setting(CFG_CHAN, 18'd1);
        send_request(1'b1, 31'd77, 1'b0);
        repeat (3) send_request(1'b0, 31'h7FFF_FFFF, 1'b0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 33 : 0;
            for (int seg = 0; seg < 10; seg++) begin
                retune();
                repeat (51) send_random();
                drain();
            end
        end

        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
